// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers included by the encoder top level
// ----------------------------------------------------------------------------
// every check samples on the rising edge of clk and is off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/dpwe_pkg.sv =====
// ----------------------------------------------------------------------------
// dpwe_pkg
// shared constants and types of the dosage probability word encoder
// ----------------------------------------------------------------------------
package dpwe_pkg;

  localparam int MAX_SUBJECTS = 65536;
  localparam int SC_W         = $clog2(MAX_SUBJECTS + 1);
  localparam int EC_MAX       = 3 * MAX_SUBJECTS;
  localparam int EC_W         = $clog2(EC_MAX + 1);

  localparam int BYTES_W  = 20;
  localparam logic [BYTES_W-1:0] BYTES_MAX = 20'hFFFFF;
  localparam int BW_WIDE  = (EC_W + 2 > BYTES_W) ? EC_W + 2 : BYTES_W;

  localparam int RAW_W    = 32;
  localparam int WORD_W   = 16;
  localparam int WORDS_PER_ITEM = 4;
  localparam int IDX_W    = $clog2(WORDS_PER_ITEM);
  localparam int EXTRA_W  = 2;

  localparam logic [WORD_W-1:0] WORD_MISSING = 16'hFFFF;
  localparam logic [WORD_W-1:0] WORD_FLAG    = 16'h8000;

  // quantizer: floor((raw * 10000 + 2^29) / 2^30)
  localparam int QPROD_W = 46;
  localparam logic [QPROD_W-1:0] SCALE    = 46'd10000;
  localparam logic [QPROD_W-1:0] HALF_Q30 = 46'd1 << 29;

  // consistency checks run on 34-bit sums of raw q2.30 values
  localparam int ERR_W = 34;
  localparam logic [ERR_W-1:0] TOL_RAW = 34'd1073;
  localparam logic [ERR_W-1:0] ONE_Q30 = 34'd1 << 30;
  localparam logic [ERR_W-1:0] SUM_LO  = ONE_Q30 - TOL_RAW;
  localparam logic [ERR_W-1:0] SUM_HI  = ONE_Q30 + TOL_RAW;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [WORDS_PER_ITEM-1:0][WORD_W-1:0] words;
    logic [IDX_W-1:0]                      last_idx;
    logic [BYTES_W-1:0]                    bytes;
  } dpwe_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dpwe_qstat_t;

endpackage

// ===== hw/rtl/dpwe_front.sv =====
// ----------------------------------------------------------------------------
// dpwe_front
// takes requests, quantizes and checks them, builds one word record each
// ----------------------------------------------------------------------------
module dpwe_front import dpwe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [RAW_W-1:0]  dosage,
  input  logic              dosage_missing,
  input  logic [RAW_W-1:0]  prob_zero,
  input  logic [RAW_W-1:0]  prob_one,
  input  logic [RAW_W-1:0]  prob_two,
  input  logic              prob_zero_missing,
  input  logic              prob_one_missing,
  input  logic              prob_two_missing,
  input  logic              last_subject,
  input  dpwe_qstat_t       qstat,
  output logic              push,
  output dpwe_rec_t         rec
);

  function automatic logic [WORD_W-1:0] quant(input logic [RAW_W-1:0] raw);
    logic [QPROD_W-1:0] prod;
    prod = QPROD_W'(raw) * SCALE + HALF_Q30;
    return prod[QPROD_W-1:30];
  endfunction

  logic              advance;

  // stage 1: registered request
  logic              s1_valid;
  logic [RAW_W-1:0]  s1_dosage;
  logic [RAW_W-1:0]  s1_p0;
  logic [RAW_W-1:0]  s1_p1;
  logic [RAW_W-1:0]  s1_p2;
  logic              s1_dmiss;
  logic              s1_pmiss;
  logic              s1_last;

  // stage 2: quantized values and check flags
  logic              s2_valid;
  logic [WORD_W-1:0] s2_qd;
  logic [WORD_W-1:0] s2_q0;
  logic [WORD_W-1:0] s2_q1;
  logic [WORD_W-1:0] s2_q2;
  logic              s2_sum_ok;
  logic              s2_dos_ok;
  logic              s2_p0_nz;
  logic              s2_p2_nz;
  logic              s2_dmiss;
  logic              s2_pmiss;
  logic              s2_last;

  logic [ERR_W-1:0]  sum3;
  logic [ERR_W-1:0]  dos_x;
  logic [ERR_W-1:0]  dos_d;

  // block counters
  logic [SC_W-1:0]    sc;
  logic [EC_W-1:0]    ec;
  logic [SC_W-1:0]    sc_next;
  logic [EC_W:0]      ec_sum;
  logic [EC_W-1:0]    ec_next;
  logic [BW_WIDE-1:0] bytes_wide;
  logic [EXTRA_W-1:0] extras;

  assign advance    = !s2_valid || !qstat.full;
  assign item_stall = !advance;
  assign push       = s2_valid && !qstat.full;

  assign sum3  = ERR_W'(s1_p0) + ERR_W'(s1_p1) + ERR_W'(s1_p2);
  assign dos_x = ERR_W'(s1_p1) + {1'b0, s1_p2, 1'b0};
  assign dos_d = ERR_W'(s1_dosage);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dosage <= dosage;
      s1_p0     <= prob_zero;
      s1_p1     <= prob_one;
      s1_p2     <= prob_two;
      s1_dmiss  <= dosage_missing;
      s1_pmiss  <= prob_zero_missing | prob_one_missing | prob_two_missing;
      s1_last   <= last_subject;

      s2_qd     <= quant(s1_dosage);
      s2_q0     <= quant(s1_p0);
      s2_q1     <= quant(s1_p1);
      s2_q2     <= quant(s1_p2);
      s2_sum_ok <= (sum3 >= SUM_LO) && (sum3 <= SUM_HI);
      s2_dos_ok <= (dos_x + TOL_RAW >= dos_d) && (dos_x <= dos_d + TOL_RAW);
      s2_p0_nz  <= (s1_p0 != '0);
      s2_p2_nz  <= (s1_p2 != '0);
      s2_dmiss  <= s1_dmiss;
      s2_pmiss  <= s1_pmiss;
      s2_last   <= s1_last;
    end
  end

  // word record of the subject in stage 2
  always_comb begin
    rec.words    = '0;
    rec.last_idx = '0;
    extras       = '0;
    priority if (s2_dmiss) begin
      rec.words[0] = WORD_MISSING;
    end else if (s2_pmiss) begin
      rec.words[0] = s2_qd | WORD_FLAG;
      rec.words[1] = WORD_MISSING;
      rec.last_idx = IDX_W'(1);
      extras       = EXTRA_W'(1);
    end else if (s2_sum_ok && s2_dos_ok) begin
      if (s2_p0_nz && s2_p2_nz) begin
        rec.words[0] = s2_qd | WORD_FLAG;
        rec.words[1] = s2_q1;
        rec.last_idx = IDX_W'(1);
        extras       = EXTRA_W'(1);
      end else begin
        rec.words[0] = s2_qd;
      end
    end else begin
      rec.words[0] = s2_qd | WORD_FLAG;
      rec.words[1] = s2_q1 | WORD_FLAG;
      rec.words[2] = s2_q0;
      rec.words[3] = s2_q2;
      rec.last_idx = IDX_W'(3);
      extras       = EXTRA_W'(3);
    end

    // saturating block counters, byte count for the last subject
    sc_next    = (sc < SC_W'(MAX_SUBJECTS)) ? sc + SC_W'(1) : sc;
    ec_sum     = (EC_W + 1)'(ec) + (EC_W + 1)'(extras);
    ec_next    = (ec_sum > (EC_W + 1)'(EC_MAX)) ? EC_W'(EC_MAX) : ec_sum[EC_W-1:0];
    bytes_wide = (BW_WIDE'(sc_next) + BW_WIDE'(ec_next)) << 1;
    if (!s2_last) begin
      rec.bytes = '0;
    end else if (bytes_wide > BW_WIDE'(BYTES_MAX)) begin
      rec.bytes = BYTES_MAX;
    end else begin
      rec.bytes = bytes_wide[BYTES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc <= '0;
      ec <= '0;
    end else if (push) begin
      if (s2_last) begin
        sc <= '0;
        ec <= '0;
      end else begin
        sc <= sc_next;
        ec <= ec_next;
      end
    end
  end

endmodule

// ===== hw/rtl/dpwe_queue.sv =====
// ----------------------------------------------------------------------------
// dpwe_queue
// short record queue between the front and the back
// ----------------------------------------------------------------------------
module dpwe_queue import dpwe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  dpwe_rec_t   wr_rec,
  input  logic        pop,
  output dpwe_rec_t   head,
  output dpwe_qstat_t qstat
);

  dpwe_rec_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_W + 1)'(1);
        2'b01:   count <= count - (QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/dpwe_back.sv =====
// ----------------------------------------------------------------------------
// dpwe_back
// walks the head record one word per cycle, while word_stall is low, into the output register
// ----------------------------------------------------------------------------
module dpwe_back import dpwe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dpwe_rec_t          head,
  input  dpwe_qstat_t        qstat,
  output logic               pop,
  output logic               word_valid,
  input  logic               word_stall,
  output logic [WORD_W-1:0]  word,
  output logic               region,
  output logic               last_of_run,
  output logic [BYTES_W-1:0] block_bytes
);

  logic             load;
  logic             at_last;
  logic [IDX_W-1:0] idx;

  // output register is free when empty or being taken this cycle
  assign load    = !word_valid || !word_stall;
  assign at_last = (idx == head.last_idx);
  assign pop     = load && !qstat.empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      idx        <= '0;
    end else if (load) begin
      word_valid <= !qstat.empty;
      if (!qstat.empty) begin
        idx <= at_last ? '0 : idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !qstat.empty) begin
      word        <= head.words[idx];
      region      <= (idx != '0);
      last_of_run <= at_last;
      block_bytes <= at_last ? head.bytes : '0;
    end
  end

endmodule

// ===== hw/rtl/dosage_probability_word_encoder_top.sv =====
// ----------------------------------------------------------------------------
// dosage_probability_word_encoder_top
// encodes one subject's dosage and genotype probabilities into 16-bit words
// ----------------------------------------------------------------------------
// channel   handshake               payload
// request   item_valid, item_stall  dosage, prob_*, *_missing, last_subject
// result    word_valid, word_stall  word, region, last_of_run, block_bytes
//
// a subject gives 1, 2 or 4 words; the back emits one word per cycle while
// word_stall is low; the first word passes the two front stages, the record
// queue and the output register
// item_stall rises only when the front's last stage holds a record and the
// four-entry queue is full
// rst clears pipeline valids, queue pointers and the block counters
// ----------------------------------------------------------------------------
module dosage_probability_word_encoder_top import dpwe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [RAW_W-1:0]   dosage,
  input  logic               dosage_missing,
  input  logic [RAW_W-1:0]   prob_zero,
  input  logic [RAW_W-1:0]   prob_one,
  input  logic [RAW_W-1:0]   prob_two,
  input  logic               prob_zero_missing,
  input  logic               prob_one_missing,
  input  logic               prob_two_missing,
  input  logic               last_subject,
  output logic               word_valid,
  input  logic               word_stall,
  output logic [WORD_W-1:0]  word,
  output logic               region,
  output logic               last_of_run,
  output logic [BYTES_W-1:0] block_bytes
);

`include "assert_macros.svh"

  dpwe_qstat_t q_stat;
  dpwe_rec_t   wr_rec;
  dpwe_rec_t   head_rec;
  logic        q_push;
  logic        q_pop;

  dpwe_front u_front (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .dosage            (dosage),
    .dosage_missing    (dosage_missing),
    .prob_zero         (prob_zero),
    .prob_one          (prob_one),
    .prob_two          (prob_two),
    .prob_zero_missing (prob_zero_missing),
    .prob_one_missing  (prob_one_missing),
    .prob_two_missing  (prob_two_missing),
    .last_subject      (last_subject),
    .qstat             (q_stat),
    .push              (q_push),
    .rec               (wr_rec)
  );

  dpwe_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_rec (wr_rec),
    .pop    (q_pop),
    .head   (head_rec),
    .qstat  (q_stat)
  );

  dpwe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head_rec),
    .qstat       (q_stat),
    .pop         (q_pop),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .word        (word),
    .region      (region),
    .last_of_run (last_of_run),
    .block_bytes (block_bytes)
  );

  `ASSERT_IMPLIES(a_no_overflow, q_push, !q_stat.full)
  `ASSERT_IMPLIES(a_no_underflow, q_pop, !q_stat.empty)
  `ASSERT_IMPLIES(a_bytes_on_last, word_valid && (block_bytes != '0), last_of_run)
  `ASSERT_NEXT(a_run_continues, word_valid && !word_stall && !last_of_run, word_valid)

endmodule

// ===== tb/dpwe_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpwe_tb_pkg
// subject and word records plus the word scoreboard of the encoder bench
// ----------------------------------------------------------------------------
package dpwe_tb_pkg;
  import dpwe_pkg::*;

  localparam longint SLACK = 1073;

  typedef struct {
    logic [RAW_W-1:0] dosage;
    logic             dosage_missing;
    logic [RAW_W-1:0] prob_zero;
    logic [RAW_W-1:0] prob_one;
    logic [RAW_W-1:0] prob_two;
    logic             prob_zero_missing;
    logic             prob_one_missing;
    logic             prob_two_missing;
    logic             last_subject;
  } subject_t;

  typedef struct {
    logic [WORD_W-1:0]  word;
    logic               region;
    logic               last_of_run;
    logic [BYTES_W-1:0] block_bytes;
  } word_rec_t;

  class dpwe_word_scoreboard;
    int        errors;
    longint    subjects;
    longint    extras;
    word_rec_t due_words[$];

    function new();
      errors   = 0;
      subjects = 0;
      extras   = 0;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // round(raw * 10000 / 2^30), ties up
    function logic [WORD_W-1:0] quantize(logic [RAW_W-1:0] raw);
      logic [63:0] prod;
      prod = {32'b0, raw} * 64'd10000 + (64'd1 << 29);
      return prod[45:30];
    endfunction

    function bit within_tol(longint e);
      return (e <= SLACK) && (e >= -SLACK);
    endfunction

    // works out the words one accepted subject produces
    function void note_subject(subject_t s);
      logic [WORD_W-1:0] qd;
      logic [WORD_W-1:0] w[WORDS_PER_ITEM];
      logic              rg[WORDS_PER_ITEM];
      longint            sum_err;
      longint            dos_err;
      longint            total;
      word_rec_t         rec;
      int                n;
      qd = quantize(s.dosage);
      n  = 1;
      rg[0] = 1'b0;
      if (s.dosage_missing) begin
        w[0] = WORD_MISSING;
      end else if (s.prob_zero_missing || s.prob_one_missing || s.prob_two_missing) begin
        w[0] = qd | WORD_FLAG;
        w[1] = WORD_MISSING;
        n = 2;
      end else begin
        sum_err = longint'({32'b0, s.prob_zero}) + longint'({32'b0, s.prob_one})
                + longint'({32'b0, s.prob_two}) - (longint'(1) << 30);
        dos_err = longint'({32'b0, s.prob_one}) + 2 * longint'({32'b0, s.prob_two})
                - longint'({32'b0, s.dosage});
        if (within_tol(sum_err) && within_tol(dos_err)) begin
          if (s.prob_zero != 0 && s.prob_two != 0) begin
            w[0] = qd | WORD_FLAG;
            w[1] = quantize(s.prob_one);
            n = 2;
          end else begin
            w[0] = qd;
          end
        end else begin
          w[0] = qd | WORD_FLAG;
          w[1] = WORD_FLAG | quantize(s.prob_one);
          w[2] = quantize(s.prob_zero);
          w[3] = quantize(s.prob_two);
          n = 4;
        end
      end
      for (int k = 1; k < n; k++) rg[k] = 1'b1;

      if (subjects < MAX_SUBJECTS) subjects++;
      extras += n - 1;
      if (extras > 3 * MAX_SUBJECTS) extras = 3 * MAX_SUBJECTS;

      for (int k = 0; k < n; k++) begin
        rec.word        = w[k];
        rec.region      = rg[k];
        rec.last_of_run = (k == n - 1);
        rec.block_bytes = '0;
        if (k == n - 1 && s.last_subject) begin
          total = 2 * (subjects + extras);
          rec.block_bytes = (total > BYTES_MAX) ? BYTES_MAX : total[BYTES_W-1:0];
        end
        due_words.push_back(rec);
      end
      if (s.last_subject) begin
        subjects = 0;
        extras   = 0;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_word(logic [WORD_W-1:0] word, logic region, logic last_of_run,
                    logic [BYTES_W-1:0] block_bytes);
      word_rec_t want;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("word %h arrived with nothing pending", word));
        return;
      end
      want = due_words.pop_front();
      if (word !== want.word)
        report_mismatch($sformatf("word %h, wanted %h", word, want.word));
      if (region !== want.region)
        report_mismatch($sformatf("region %b, wanted %b (word %h)", region, want.region,
                                  want.word));
      if (last_of_run !== want.last_of_run)
        report_mismatch($sformatf("last_of_run %b, wanted %b (word %h)", last_of_run,
                                  want.last_of_run, want.word));
      if (block_bytes !== want.block_bytes)
        report_mismatch($sformatf("block_bytes %0d, wanted %0d (word %h)", block_bytes,
                                  want.block_bytes, want.word));
    endtask
  endclass

endpackage

// ===== tb/tb_dosage_probability_word_encoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_dosage_probability_word_encoder_top
// drives subjects into the word encoder and checks every emitted word,
// region tag, run end and block byte count against a bit-exact predictor
// ----------------------------------------------------------------------------
module tb_dosage_probability_word_encoder_top;
  import dpwe_pkg::*;
  import dpwe_tb_pkg::*;

  localparam logic [RAW_W-1:0] ONE  = 32'h4000_0000;
  localparam logic [RAW_W-1:0] HALF = 32'h2000_0000;
  localparam logic [RAW_W-1:0] QTR  = 32'h1000_0000;
  localparam logic [RAW_W-1:0] MAXV = 32'hFFFF_FFFF;

  logic               clk               = 1'b0;
  logic               rst               = 1'b1;
  logic               item_valid        = 1'b0;
  logic               item_stall;
  logic [RAW_W-1:0]   dosage            = '0;
  logic               dosage_missing    = 1'b0;
  logic [RAW_W-1:0]   prob_zero         = '0;
  logic [RAW_W-1:0]   prob_one          = '0;
  logic [RAW_W-1:0]   prob_two          = '0;
  logic               prob_zero_missing = 1'b0;
  logic               prob_one_missing  = 1'b0;
  logic               prob_two_missing  = 1'b0;
  logic               last_subject      = 1'b0;
  logic               word_valid;
  logic               word_stall        = 1'b0;
  logic [WORD_W-1:0]  word;
  logic               region;
  logic               last_of_run;
  logic [BYTES_W-1:0] block_bytes;

  bit                  idling = 1'b1;
  dpwe_word_scoreboard sb     = new();

  dosage_probability_word_encoder_top dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .dosage(dosage),
    .dosage_missing(dosage_missing),
    .prob_zero(prob_zero),
    .prob_one(prob_one),
    .prob_two(prob_two),
    .prob_zero_missing(prob_zero_missing),
    .prob_one_missing(prob_one_missing),
    .prob_two_missing(prob_two_missing),
    .last_subject(last_subject),
    .word_valid(word_valid),
    .word_stall(word_stall),
    .word(word),
    .region(region),
    .last_of_run(last_of_run),
    .block_bytes(block_bytes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic subject_t subj(logic [RAW_W-1:0] d, logic dm, logic [RAW_W-1:0] p0,
                                    logic [RAW_W-1:0] p1, logic [RAW_W-1:0] p2,
                                    logic m0, logic m1, logic m2, logic lst);
    subject_t s;
    s.dosage            = d;
    s.dosage_missing    = dm;
    s.prob_zero         = p0;
    s.prob_one          = p1;
    s.prob_two          = p2;
    s.prob_zero_missing = m0;
    s.prob_one_missing  = m1;
    s.prob_two_missing  = m2;
    s.last_subject      = lst;
    return s;
  endfunction

  // mostly well-formed subjects near the consistency limits, the rest missing
  // flags, corrupted probabilities or plain noise
  function automatic subject_t random_subject();
    subject_t    s;
    int unsigned pick;
    int unsigned u0;
    int unsigned u1;
    longint      p2;
    longint      d;
    longint      j_sum;
    longint      j_dos;
    longint      brink;
    pick = $urandom_range(0, 99);
    if (pick >= 85) begin
      return subj($urandom, $urandom_range(0, 3) == 0, $urandom, $urandom, $urandom,
                  $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 3) == 0, $urandom_range(0, 11) == 0);
    end
    j_sum = longint'($urandom_range(0, 2 * SLACK)) - SLACK;
    j_dos = longint'($urandom_range(0, 2 * SLACK)) - SLACK;
    if (pick >= 40 && pick < 55) begin
      brink = $urandom_range(1070, 1078);
      if ($urandom_range(0, 1)) brink = -brink;
      if ($urandom_range(0, 1)) j_sum = brink;
      else j_dos = brink;
    end
    u0 = $urandom_range(0, ONE);
    if ($urandom_range(0, 5) == 0) u0 = 0;
    u1 = $urandom_range(0, ONE - u0);
    p2 = longint'(ONE) - u0 - u1 + j_sum;
    if (p2 < 0) p2 = 0;
    if ($urandom_range(0, 5) == 0) begin
      p2 = 0;
      u1 = ONE - u0;
    end
    d = u1 + 2 * p2 + j_dos;
    if (d < 0) d = 0;
    s = subj(d[31:0], 1'b0, u0, u1, p2[31:0], 1'b0, 1'b0, 1'b0,
             $urandom_range(0, 11) == 0);
    if (pick >= 55 && pick < 70)
      {s.prob_zero_missing, s.prob_one_missing, s.prob_two_missing} =
        3'($urandom_range(1, 7));
    else if (pick >= 70 && pick < 80)
      s.dosage_missing = 1'b1;
    else if (pick >= 80)
      case ($urandom_range(0, 2))
        0: s.prob_zero = $urandom;
        1: s.prob_one  = $urandom;
        default: s.prob_two = $urandom;
      endcase
    return s;
  endfunction

  // called just after a rising edge; returns at the edge that takes the request
  task send_subject(subject_t s);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      item_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    dosage            = s.dosage;
    dosage_missing    = s.dosage_missing;
    prob_zero         = s.prob_zero;
    prob_one          = s.prob_one;
    prob_two          = s.prob_two;
    prob_zero_missing = s.prob_zero_missing;
    prob_one_missing  = s.prob_one_missing;
    prob_two_missing  = s.prob_two_missing;
    last_subject      = s.last_subject;
    item_valid        = 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_subject(s);
  endtask

  task drain_words();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side: random stall bursts, started only while idling is set
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        word_stall = 1'b1;
        hold = $urandom_range(0, 4);
      end else begin
        word_stall = 1'b0;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && word_valid && !word_stall)
        sb.check_word(word, region, last_of_run, block_bytes);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // directed subjects
    send_subject(subj(32'h1234_5678, 1'b1, MAXV, 0, 0, 1'b1, 1'b0, 1'b0, 1'b0));
    send_subject(subj(0, 1'b0, ONE, 0, 0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(32'h8000_0000, 1'b0, 0, 0, ONE, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE, 1'b0, QTR, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE, 1'b0, QTR, HALF, QTR, 1'b1, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE, 1'b0, QTR, HALF, QTR, 1'b0, 1'b1, 1'b0, 1'b0));
    send_subject(subj(ONE, 1'b0, QTR, HALF, QTR, 1'b0, 1'b0, 1'b1, 1'b0));
    send_subject(subj(MAXV, 1'b0, 0, 0, 0, 1'b0, 1'b1, 1'b0, 1'b0));
    // sum and dosage checks on both sides of the tolerance
    send_subject(subj(ONE, 1'b0, QTR + 1073, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE, 1'b0, QTR + 1074, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE, 1'b0, QTR - 1073, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE, 1'b0, QTR - 1074, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE - 1073, 1'b0, QTR, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE - 1074, 1'b0, QTR, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE + 1073, 1'b0, QTR, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(ONE + 1074, 1'b0, QTR, HALF, QTR, 1'b0, 1'b0, 1'b0, 1'b1));
    // values above nominal and all-zero probabilities
    send_subject(subj(MAXV, 1'b0, MAXV, MAXV, MAXV, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(0, 1'b0, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1));
    // 2^25 quantizes to an exact half and rounds up
    send_subject(subj(32'h0200_0000, 1'b0, 0, 32'h0200_0000, 0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(32'h6000_0000, 1'b0, 0, HALF, HALF, 1'b0, 1'b0, 1'b0, 1'b0));
    send_subject(subj(0, 1'b1, 0, 0, 0, 1'b0, 1'b0, 1'b0, 1'b1));
    drain_words();

    for (int i = 0; i < 200; i++) begin
      send_subject(random_subject());
      if (i == 120) drain_words();
    end

    // no idling from here on
    idling = 1'b0;
    for (int i = 0; i < 30; i++) send_subject(random_subject());

    drain_words();
    repeat (12) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/dpwe_pkg.sv
hw/rtl/dpwe_front.sv
hw/rtl/dpwe_queue.sv
hw/rtl/dpwe_back.sv
hw/rtl/dosage_probability_word_encoder_top.sv
tb/dpwe_tb_pkg.sv
tb/tb_dosage_probability_word_encoder_top.sv
